>>> rtl/pmucw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmucw_pkg
// Shared types and constants of the PMU control write checker.
// ----------------------------------------------------------------------------
package pmucw_pkg;

    localparam int unsigned IdxWidth   = 9;
    localparam int unsigned ValueWidth = 64;
    localparam int unsigned CfgIdxWidth = 2;

    typedef logic [IdxWidth-1:0]   reg_index_t;
    typedef logic [ValueWidth-1:0] value_t;

    typedef enum logic [1:0] {
        CAUSE_NONE     = 2'd0,
        CAUSE_OVERFLOW = 2'd1,
        CAUSE_ADDR_CAP = 2'd2,
        CAUSE_BAD_COMB = 2'd3
    } reject_cause_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_SYSTEM_WIDE = 2'd0,
        CFG_THREADS_ON  = 2'd1,
        CFG_DBG_IN_USE  = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_index_t;

    localparam reg_index_t IDX_PMC_FIRST      = 9'd4;
    localparam reg_index_t IDX_PMC_EMUL_FIRST = 9'd10;
    localparam reg_index_t IDX_PMC_LAST       = 9'd15;
    localparam reg_index_t IDX_OPCODE_MATCH   = 9'd32;
    localparam reg_index_t IDX_RANGE_CTRL     = 9'd37;
    localparam reg_index_t IDX_IBR_CONFIG     = 9'd38;
    localparam reg_index_t IDX_CAPTURE_A      = 9'd39;
    localparam reg_index_t IDX_CAPTURE_B      = 9'd40;
    localparam reg_index_t IDX_DBR_CONFIG     = 9'd41;
    localparam reg_index_t IDX_CAPTURE_C      = 9'd42;

    localparam int unsigned PRIV_BIT_PMC   = 6;
    localparam int unsigned PRIV_BIT_RANGE = 4;

    localparam value_t DBR_ENABLE_MASK = 64'h0001_e000_0000_0000;
    localparam value_t DBR_TAG_MASK    = 64'h0000_0000_1818_1818;
    localparam value_t IBR_IGNORE_MASK = 64'h0000_0000_0000_0492;
    localparam logic [2:0] CAPTURE_ERRATUM_CODE = 3'd4;

    localparam value_t SHADOW_OPCODE_RESET = 64'h030f_01ff_ffff_ffff;
    localparam value_t SHADOW_IBR_RESET    = 64'h0000_0000_0000_0db6;
    localparam value_t SHADOW_DBR_RESET    = 64'h0000_2078_fefe_fefe;

    function automatic logic field_0_or_2(input logic [1:0] f);
        begin
            field_0_or_2 = (f == 2'd0) || (f == 2'd2);
        end
    endfunction

endpackage : pmucw_pkg
`default_nettype wire

>>> rtl/pmu_control_write_checker_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmu_control_write_checker_top
// Checks and adjusts writes to performance-monitor control registers.
// ----------------------------------------------------------------------------
// Each request transaction carries one control register write; the block
// returns exactly one response transaction per request, in order. A request
// is captured into an input register, checked and adjusted combinationally,
// and placed in a result register, so a new request is taken every cycle
// unless rsp_ready holds back the response. Throughput is one write per cycle
// without stall, set by the single check stage, which also updates the three
// shadow values so that a following write sees them at once. Configuration
// writes take effect on the next cycle and are expected only while idle.
// ----------------------------------------------------------------------------
module pmu_control_write_checker_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write_en,
    input  wire logic [pmucw_pkg::CfgIdxWidth-1:0]   cfg_index,
    input  wire logic                                cfg_data,
    input  wire logic                                req_valid,
    output logic                                     req_ready,
    input  wire logic [pmucw_pkg::IdxWidth-1:0]      reg_index,
    input  wire logic [pmucw_pkg::ValueWidth-1:0]    write_value,
    input  wire logic                                no_emul64,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_ready,
    output logic [pmucw_pkg::ValueWidth-1:0]         out_value,
    output logic                                     rejected,
    output logic [1:0]                               reject_cause,
    output logic                                     claim_debug_regs
);
    import pmucw_pkg::*;

    logic          system_wide_reg;
    logic          threads_on_reg;
    logic          dbg_in_use_reg;

    logic          s1_valid_reg;
    reg_index_t    s1_index_reg;
    value_t        s1_value_reg;
    logic          s1_no_emul_reg;

    value_t        shadow_opcode_reg;
    value_t        shadow_ibr_reg;
    value_t        shadow_dbr_reg;

    logic          rsp_valid_reg;
    value_t        out_value_reg;
    reject_cause_t cause_reg;
    logic          claim_reg;

    logic          advance;
    logic          is_pmc;
    logic          is_capture;
    logic          is_range;
    logic          is_opcode;
    logic          is_ibr;
    logic          is_dbr;
    value_t        v32;
    value_t        v38;
    value_t        v41;
    logic          bad_comb;
    reject_cause_t cause_next;
    value_t        value_next;
    logic          claim_next;
    logic          shadow_we;

    assign advance   = !rsp_valid_reg || rsp_ready;
    assign req_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            system_wide_reg <= 1'b0;
            threads_on_reg  <= 1'b0;
            dbg_in_use_reg  <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SYSTEM_WIDE: system_wide_reg <= cfg_data;
                CFG_THREADS_ON:  threads_on_reg  <= cfg_data;
                CFG_DBG_IN_USE:  dbg_in_use_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Decode the register index
    always_comb
    begin
        is_pmc     = (s1_index_reg >= IDX_PMC_FIRST) && (s1_index_reg <= IDX_PMC_LAST);
        is_capture = (s1_index_reg == IDX_CAPTURE_A) || (s1_index_reg == IDX_CAPTURE_B) ||
                     (s1_index_reg == IDX_CAPTURE_C);
        is_range   = (s1_index_reg == IDX_RANGE_CTRL);
        is_opcode  = (s1_index_reg == IDX_OPCODE_MATCH);
        is_ibr     = (s1_index_reg == IDX_IBR_CONFIG);
        is_dbr     = (s1_index_reg == IDX_DBR_CONFIG);
    end

    always_comb
    begin
        v32 = is_opcode ? s1_value_reg : shadow_opcode_reg;
        v38 = is_ibr    ? s1_value_reg : shadow_ibr_reg;
        v41 = is_dbr    ? s1_value_reg : shadow_dbr_reg;
        bad_comb = (v41[48:45] == 4'd0) && !v32[57] &&
                   (field_0_or_2(v38[2:1]) || field_0_or_2(v38[5:4]));

        cause_next = CAUSE_NONE;
        value_next = s1_value_reg;
        claim_next = 1'b0;
        shadow_we  = 1'b0;

        if (is_pmc)
        begin
            if ((s1_index_reg >= IDX_PMC_EMUL_FIRST) && !s1_no_emul_reg && threads_on_reg)
                cause_next = CAUSE_OVERFLOW;
            else
                value_next[PRIV_BIT_PMC] = system_wide_reg;
        end
        else if (is_capture)
        begin
            if (threads_on_reg && (s1_value_reg[10:8] == CAPTURE_ERRATUM_CODE))
                cause_next = CAUSE_ADDR_CAP;
            else
                value_next[PRIV_BIT_PMC] = system_wide_reg;
        end
        else if (is_range)
        begin
            value_next[PRIV_BIT_RANGE] = system_wide_reg;
        end
        else if (is_opcode || is_ibr || is_dbr)
        begin
            if (bad_comb)
                cause_next = CAUSE_BAD_COMB;
            else
            begin
                shadow_we = 1'b1;
                if (!dbg_in_use_reg)
                begin
                    if (is_dbr && ((s1_value_reg & DBR_ENABLE_MASK) != '0) &&
                        ((s1_value_reg & DBR_TAG_MASK) != DBR_TAG_MASK))
                        claim_next = 1'b1;
                    if (is_ibr && ((s1_value_reg & IBR_IGNORE_MASK) != IBR_IGNORE_MASK))
                        claim_next = 1'b1;
                end
            end
        end

        if (cause_next != CAUSE_NONE)
            value_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            shadow_opcode_reg <= SHADOW_OPCODE_RESET;
            shadow_ibr_reg    <= SHADOW_IBR_RESET;
            shadow_dbr_reg    <= SHADOW_DBR_RESET;
        end
        else
        begin
            if (req_ready)
                s1_valid_reg <= req_valid;
            if (advance)
                rsp_valid_reg <= s1_valid_reg;
            if (s1_valid_reg && advance && shadow_we)
            begin
                if (is_opcode)
                    shadow_opcode_reg <= s1_value_reg;
                if (is_ibr)
                    shadow_ibr_reg <= s1_value_reg;
                if (is_dbr)
                    shadow_dbr_reg <= s1_value_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_index_reg   <= reg_index;
            s1_value_reg   <= write_value;
            s1_no_emul_reg <= no_emul64;
        end
        if (s1_valid_reg && advance)
        begin
            out_value_reg <= value_next;
            cause_reg     <= cause_next;
            claim_reg     <= claim_next;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign out_value        = out_value_reg;
    assign rejected         = (cause_reg != CAUSE_NONE);
    assign reject_cause     = cause_reg;
    assign claim_debug_regs = claim_reg;

`ifndef SYNTHESIS
    a_reject_clears_payload: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (cause_reg != CAUSE_NONE) |-> (out_value_reg == '0) && !claim_reg)
        else $error("rejected transaction carries value or claim");

    a_stage_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_value_reg))
        else $error("input stage lost a transaction under stall");

    a_shadow_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_valid_reg && advance) |=> $stable(shadow_opcode_reg) &&
        $stable(shadow_ibr_reg) && $stable(shadow_dbr_reg))
        else $error("shadow changed without an accepted write");

    a_claim_only_on_debug_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance && claim_next |-> (is_ibr || is_dbr) && !dbg_in_use_reg)
        else $error("debug claim raised for wrong register");
`endif

endmodule : pmu_control_write_checker_top
`default_nettype wire
